// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LMS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LMS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LMS_ASSERT_IMP(label, clk, rst, ante, cons)
`define LMS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/lms_pkg.sv =====
package lms_pkg;

  localparam int MAX_SEQUENCE = 65536;
  localparam int MAX_WINDOW   = 32;

  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int SYM_W     = 8;
  localparam int POS_W     = 16;
  localparam int WIN_W     = 17;
  localparam int SCORE_W   = 6;
  localparam int TIE_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_LIMIT   = 1'b1;

  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 6'd9;
  localparam logic [CFG_W-1:0] SCORE_LIMIT_RESET   = 6'd0;

  localparam logic [TIE_W-1:0] TIE_MAX = 16'hFFFF;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPARE = 1'b1;

  localparam logic KIND_HIT     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic             command;
    logic             start_new;
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] source_pos;
    logic [POS_W-1:0] target_pos;
    logic             last_target;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [WIN_W-1:0]   source_start;
    logic [WIN_W-1:0]   window_start;
    logic [WIN_W-1:0]   window_end;
    logic [SCORE_W-1:0] score;
    logic [TIE_W-1:0]   tie_count;
    logic               last;
  } result_t;

  typedef struct packed {
    logic load;
    logic start;
    logic run;
    logic finish;
    logic push_hit;
    logic push_sum;
  } lms_cmd_t;

  typedef struct packed {
    logic valid;
    logic last_issue;
    logic hit;
    logic summary;
  } lms_stat_t;

endpackage

// ===== hw/rtl/lms_ctrl.sv =====
module lms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_command,
  input  logic              fifo_full,
  input  lms_pkg::lms_stat_t stat,
  output logic              item_ready,
  output lms_pkg::lms_cmd_t  cmd
);
  import lms_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    READ,
    DRAIN,
    UPDATE,
    EMIT_HIT,
    EMIT_SUM
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (item_valid && item_ready) begin
          if (item_command == CMD_COMPARE) begin
            cmd.start  = 1'b1;
            state_next = READ;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      READ: begin
        if (!stat.valid) begin
          state_next = UPDATE;
        end else begin
          cmd.run = 1'b1;
          if (stat.last_issue) begin
            state_next = DRAIN;
          end
        end
      end
      DRAIN: begin
        state_next = UPDATE;
      end
      UPDATE: begin
        cmd.finish = 1'b1;
        state_next = EMIT_HIT;
      end
      EMIT_HIT: begin
        if (!stat.hit) begin
          state_next = EMIT_SUM;
        end else if (!fifo_full) begin
          cmd.push_hit = 1'b1;
          state_next   = EMIT_SUM;
        end
      end
      EMIT_SUM: begin
        if (!stat.summary) begin
          state_next = IDLE;
        end else if (!fifo_full) begin
          cmd.push_sum = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      item_ready <= 1'b0;
    end else begin
      state      <= state_next;
      item_ready <= (state_next == IDLE);
    end
  end

endmodule

// ===== hw/rtl/lms_dpath.sv =====
module lms_dpath #(
  parameter int MAX_SEQ = lms_pkg::MAX_SEQUENCE
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lms_pkg::lms_cmd_t          cmd,
  input  lms_pkg::item_t             item,
  input  logic [lms_pkg::CFG_W-1:0]  window_length,
  input  logic [lms_pkg::CFG_W-1:0]  score_limit,
  output lms_pkg::lms_stat_t         stat,
  output lms_pkg::result_t           result
);
  import lms_pkg::*;

  localparam int AW = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
  localparam int LW = $clog2(MAX_SEQ + 1);
  localparam int CW = (LW > WIN_W) ? LW : WIN_W;
  localparam int SW = (AW > WIN_W) ? AW : WIN_W;

  logic [SYM_W-1:0] mem [MAX_SEQ];

  logic [LW-1:0]    seq_len;
  logic [LW-1:0]    seq_base;
  logic [POS_W-1:0] src;
  logic [POS_W-1:0] trg;
  logic             last_t;
  logic             valid;
  logic [CFG_W-1:0] len;
  logic [CFG_W-1:0] idx;
  logic [CFG_W-1:0] acc;
  logic [CFG_W-1:0] acc_next;
  logic [CFG_W-1:0] best;
  logic [CFG_W-1:0] best_next;
  logic [TIE_W-1:0] ties;
  logic [TIE_W-1:0] ties_next;
  logic [CFG_W-1:0] sum_score;
  logic [TIE_W-1:0] sum_ties;
  logic             hit_flag;
  logic             sum_flag;
  logic             hit_next;
  logic             sum_next;
  logic             rd_pend;
  logic [SYM_W-1:0] rd_a;
  logic [SYM_W-1:0] rd_b;
  logic [CFG_W-1:0] len_eff;
  logic [CW-1:0]    src_end;
  logic [CW-1:0]    trg_end;
  logic             valid_next;
  logic [SW-1:0]    addr_a;
  logic [SW-1:0]    addr_b;

  always_comb begin
    if (window_length == '0) begin
      len_eff = CFG_W'(1);
    end else if (int'(window_length) > MAX_WINDOW) begin
      len_eff = CFG_W'(MAX_WINDOW);
    end else begin
      len_eff = window_length;
    end
  end

  assign seq_base   = item.start_new ? '0 : seq_len;
  assign src_end    = CW'(item.source_pos) + CW'(len_eff);
  assign trg_end    = CW'(item.target_pos) + CW'(len_eff);
  assign valid_next = (item.source_pos != item.target_pos) &&
                      (src_end <= CW'(seq_len)) && (trg_end <= CW'(seq_len));

  assign addr_a = SW'(src) + SW'(idx);
  assign addr_b = SW'(trg) + SW'(idx);

  assign acc_next = (rd_pend && (rd_a == rd_b)) ? acc + CFG_W'(1) : acc;

  always_comb begin
    best_next = best;
    ties_next = ties;
    if (valid) begin
      if (acc > best) begin
        best_next = acc;
        ties_next = TIE_W'(1);
      end else if (acc == best) begin
        if (ties != TIE_MAX) begin
          ties_next = ties + TIE_W'(1);
        end
      end
    end
  end

  assign hit_next = valid && (acc >= score_limit);
  assign sum_next = last_t && (best_next >= score_limit);

  // sequence store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.load && (seq_base < LW'(MAX_SEQ))) begin
      mem[seq_base[AW-1:0]] <= item.symbol;
    end
    if (cmd.run) begin
      rd_a <= mem[addr_a[AW-1:0]];
      rd_b <= mem[addr_b[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      src    <= item.source_pos;
      trg    <= item.target_pos;
      last_t <= item.last_target;
      len    <= len_eff;
      valid  <= valid_next;
      idx    <= '0;
      acc    <= '0;
    end else begin
      if (cmd.run) begin
        idx <= idx + CFG_W'(1);
      end
      acc <= acc_next;
    end
    if (cmd.finish) begin
      sum_score <= best_next;
      sum_ties  <= ties_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len  <= '0;
      best     <= '0;
      ties     <= '0;
      rd_pend  <= 1'b0;
      hit_flag <= 1'b0;
      sum_flag <= 1'b0;
    end else begin
      rd_pend <= cmd.run;
      if (cmd.load) begin
        seq_len <= (seq_base < LW'(MAX_SEQ)) ? seq_base + LW'(1) : seq_base;
      end
      if (cmd.finish) begin
        hit_flag <= hit_next;
        sum_flag <= sum_next;
        if (last_t) begin
          best <= '0;
          ties <= '0;
        end else begin
          best <= best_next;
          ties <= ties_next;
        end
      end
    end
  end

  assign stat.valid      = valid;
  assign stat.last_issue = (idx == len - CFG_W'(1));
  assign stat.hit        = hit_flag;
  assign stat.summary    = sum_flag;

  always_comb begin
    if (cmd.push_sum) begin
      result.kind         = KIND_SUMMARY;
      result.source_start = WIN_W'(src) + WIN_W'(1);
      result.window_start = WIN_W'(src) + WIN_W'(1);
      result.window_end   = WIN_W'(src) + WIN_W'(len);
      result.score        = sum_score;
      result.tie_count    = sum_ties;
      result.last         = 1'b1;
    end else begin
      result.kind         = KIND_HIT;
      result.source_start = WIN_W'(src) + WIN_W'(1);
      result.window_start = WIN_W'(trg) + WIN_W'(1);
      result.window_end   = WIN_W'(trg) + WIN_W'(len);
      result.score        = acc;
      result.tie_count    = TIE_W'(1);
      result.last         = !sum_flag;
    end
  end

endmodule

// ===== hw/rtl/lms_fifo.sv =====
module lms_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lms_pkg::result_t din,
  output logic             full,
  output logic             valid,
  input  logic             ready,
  output lms_pkg::result_t dout
);
  import lms_pkg::*;

  result_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign dout  = entry[rd_ptr];
  assign pop   = valid && ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hw/rtl/lmer_match_score_search_core.sv =====
// Load beats: one per cycle, back to back, no result.
// Compare beats: one symbol pair per cycle over the effective window length, from the two
// read ports of the sequence store; a skipped compare goes from READ straight to UPDATE.
// A hit enters the two-beat output queue in state EMIT_HIT, after READ, DRAIN and UPDATE,
// a summary in state EMIT_SUM after it; a full queue stalls the controller.
// Reset clears length, best score, ties and queue, sets window 9, limit 0; store kept.
`include "assert_macros.svh"

module lmer_match_score_search_core #(
  parameter int MAX_SEQUENCE = lms_pkg::MAX_SEQUENCE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  lms_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output lms_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [lms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lms_pkg::CFG_W-1:0]     cfg_data
);
  import lms_pkg::*;

  logic [CFG_W-1:0] window_length;
  logic [CFG_W-1:0] score_limit;
  lms_cmd_t         cmd;
  lms_stat_t        stat;
  result_t          dp_result;
  logic             fifo_full;
  logic             fifo_push;
  logic             compare_taken;
  logic             summary_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RESET;
      score_limit   <= SCORE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data;
        REG_SCORE_LIMIT:   score_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fifo_push = cmd.push_hit || cmd.push_sum;

  lms_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_command (item.command),
    .fifo_full    (fifo_full),
    .stat         (stat),
    .item_ready   (item_ready),
    .cmd          (cmd)
  );

  lms_dpath #(
    .MAX_SEQ (MAX_SEQUENCE)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .item          (item),
    .window_length (window_length),
    .score_limit   (score_limit),
    .stat          (stat),
    .result        (dp_result)
  );

  lms_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (fifo_push),
    .din   (dp_result),
    .full  (fifo_full),
    .valid (result_valid),
    .ready (result_ready),
    .dout  (result)
  );

  assign compare_taken = item_valid && item_ready && (item.command == CMD_COMPARE);
  assign summary_beat  = result_valid && (result.kind == KIND_SUMMARY);

  `LMS_ASSERT_IMP(a_no_overflow, clk, rst, fifo_push, !fifo_full)
  `LMS_ASSERT_NXT(a_busy_after_compare, clk, rst, compare_taken, !item_ready)
  `LMS_ASSERT_IMP(a_summary_is_last, clk, rst, summary_beat, result.last)

endmodule
